// File: hw/rtl/itoa_pkg.sv
// Shared types and constants for the integer to ASCII converter.
// Used by itoa_dabble, itoa_emit and integer_to_ascii_radix; depends on nothing.
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS = 64;
    localparam int BCD_DIGITS = 20;
    localparam int DIGIT_BITS = 4 * BCD_DIGITS;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A_LOW = 8'h61;
    localparam logic [7:0] CHAR_F_LOW = 8'h66;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef struct packed {
        logic                  valid;
        radix_t                radix;
        logic                  neg;
        logic [DIGIT_BITS-1:0] digits;
    } emit_load_t;

endpackage

`default_nettype wire

// File: hw/rtl/itoa_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on itoa_pkg.
`default_nettype none

module itoa_dabble (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [itoa_pkg::VALUE_BITS-1:0]      mag,
    output logic                                      busy,
    output logic                                      done,
    output logic [itoa_pkg::DIGIT_BITS-1:0]           bcd
);

    localparam int CNT_BITS = $clog2(itoa_pkg::VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(itoa_pkg::VALUE_BITS - 1);

    logic [itoa_pkg::VALUE_BITS-1:0] bin_reg, bin_next;
    logic [itoa_pkg::DIGIT_BITS-1:0] bcd_reg, bcd_next;
    logic [itoa_pkg::DIGIT_BITS-1:0] bcd_adj;
    logic [CNT_BITS-1:0]             cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[itoa_pkg::DIGIT_BITS-2:0], bin_reg[itoa_pkg::VALUE_BITS-1]};
            bin_next = {bin_reg[itoa_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/itoa_emit.sv
// Digit shifter and character output stage: one digit leaves per cycle while out_ready
// does not stall it, leading zeros are dropped and the character sits in an output register.
// Depends on itoa_pkg.
`default_nettype none

module itoa_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire itoa_pkg::emit_load_t load,
    output logic                      busy,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                text_char,
    output logic                      last
);

    localparam int DW = itoa_pkg::DIGIT_BITS;
    localparam logic [6:0] CNT_DEC = 7'd20;
    localparam logic [6:0] CNT_HEX = 7'd16;
    localparam logic [6:0] CNT_OCT = 7'd22;
    localparam logic [6:0] CNT_BIN = 7'd64;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = itoa_pkg::CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = itoa_pkg::CHAR_A_LOW + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

    logic [DW-1:0]    dig_reg, dig_next, dig_shift;
    logic [6:0]       remain_reg, remain_next;
    itoa_pkg::radix_t radix_reg, radix_next;
    logic             neg_reg, neg_next;
    logic             started_reg, started_next;
    logic             active_reg, active_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [3:0]       top_digit;
    logic             take;

    always_comb
    begin
        case (radix_reg)
            itoa_pkg::RADIX_DEC, itoa_pkg::RADIX_HEX:
            begin
                top_digit = dig_reg[DW-1 -: 4];
                dig_shift = {dig_reg[DW-5:0], 4'b0};
            end
            itoa_pkg::RADIX_OCT:
            begin
                top_digit = {1'b0, dig_reg[DW-1 -: 3]};
                dig_shift = {dig_reg[DW-4:0], 3'b0};
            end
            default:
            begin
                top_digit = {3'b0, dig_reg[DW-1]};
                dig_shift = {dig_reg[DW-2:0], 1'b0};
            end
        endcase
    end

    assign take = !valid_reg || out_ready;

    always_comb
    begin
        dig_next     = dig_reg;
        remain_next  = remain_reg;
        radix_next   = radix_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        active_next  = active_reg;
        valid_next   = valid_reg && !out_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        if (load.valid)
        begin
            radix_next   = load.radix;
            neg_next     = load.neg;
            started_next = 1'b0;
            active_next  = 1'b1;
            case (load.radix)
                itoa_pkg::RADIX_DEC:
                begin
                    dig_next    = load.digits;
                    remain_next = CNT_DEC;
                end
                itoa_pkg::RADIX_HEX:
                begin
                    dig_next    = {load.digits[itoa_pkg::VALUE_BITS-1:0], 16'b0};
                    remain_next = CNT_HEX;
                end
                itoa_pkg::RADIX_OCT:
                begin
                    dig_next    = {2'b0, load.digits[itoa_pkg::VALUE_BITS-1:0], 14'b0};
                    remain_next = CNT_OCT;
                end
                default:
                begin
                    dig_next    = {load.digits[itoa_pkg::VALUE_BITS-1:0], 16'b0};
                    remain_next = CNT_BIN;
                end
            endcase
        end
        else if (active_reg)
        begin
            if (neg_reg)
            begin
                if (take)
                begin
                    valid_next = 1'b1;
                    char_next  = itoa_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    neg_next   = 1'b0;
                end
            end
            else if (!started_reg && top_digit == 4'd0 && remain_reg > 7'd1)
            begin
                dig_next    = dig_shift;
                remain_next = remain_reg - 7'd1;
            end
            else if (take)
            begin
                valid_next   = 1'b1;
                char_next    = glyph(top_digit);
                last_next    = (remain_reg == 7'd1);
                dig_next     = dig_shift;
                remain_next  = remain_reg - 7'd1;
                started_next = 1'b1;
                if (remain_reg == 7'd1)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            neg_reg    <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg     <= dig_next;
        remain_reg  <= remain_next;
        radix_reg   <= radix_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign busy      = active_reg;
    assign out_valid = valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_ascii_radix.sv
// Integer to ASCII text converter, one character per output request.
// Decimal: bit-serial BCD conversion in itoa_dabble, then itoa_emit sends any minus
// sign and the digits, leading zeros dropped. Input waits until itoa_emit is idle.
// Hex, octal, binary: the value is loaded into itoa_emit as 16, 22 or 64 digit slots.
// Asynchronous active-low reset clears FSM, busy and valid flags; no memory to clear.
// Depends on itoa_pkg, itoa_dabble and itoa_emit.
`default_nettype none

module integer_to_ascii_radix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic signed [63:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              text_char,
    output logic                    last
);

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } state_t;

    state_t                          state_reg, state_next;
    logic                            neg_reg, neg_next;
    logic [itoa_pkg::VALUE_BITS-1:0] value_u;
    logic [itoa_pkg::VALUE_BITS-1:0] mag;
    logic                            accept;
    logic                            dab_start;
    logic                            dab_busy;
    logic                            dab_done;
    logic [itoa_pkg::DIGIT_BITS-1:0] dab_bcd;
    logic                            emit_busy;
    itoa_pkg::emit_load_t            emit_load;

    assign value_u  = value;
    assign mag      = value_u[63] ? (~value_u + 64'd1) : value_u;
    assign in_ready = (state_reg == ST_IDLE) && !emit_busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        dab_start        = 1'b0;
        emit_load.valid  = 1'b0;
        emit_load.radix  = itoa_pkg::radix_t'(cmd);
        emit_load.neg    = 1'b0;
        emit_load.digits = {16'b0, value_u};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (itoa_pkg::radix_t'(cmd) == itoa_pkg::RADIX_DEC)
                    begin
                        dab_start  = 1'b1;
                        neg_next   = value_u[63];
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        emit_load.valid = 1'b1;
                    end
                end
            end
            ST_CONV:
            begin
                emit_load.radix  = itoa_pkg::RADIX_DEC;
                emit_load.neg    = neg_reg;
                emit_load.digits = dab_bcd;
                if (dab_done)
                begin
                    emit_load.valid = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    itoa_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag),
        .busy  (dab_busy),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    itoa_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_conv_state: assert property (@(posedge clk) disable iff (!rst_n)
        dab_busy |-> state_reg == ST_CONV)
        else $error("BCD conversion running outside the conversion state");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((text_char >= itoa_pkg::CHAR_ZERO && text_char <= itoa_pkg::CHAR_NINE)
            || (text_char >= itoa_pkg::CHAR_A_LOW && text_char <= itoa_pkg::CHAR_F_LOW)
            || (text_char == itoa_pkg::CHAR_MINUS && !last)))
        else $error("Output character is not a digit, letter or leading minus");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("New request taken while the previous one is still in work");
`endif

endmodule

`default_nettype wire

// File: verif/integer_to_ascii_radix_tb.sv
// Self-checking testbench for integer_to_ascii_radix: numbers go in with a radix, their
// text is predicted here and compared character by character under random stalls.
// Depends on itoa_pkg and the integer_to_ascii_radix RTL.
module integer_to_ascii_radix_tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 11;
    localparam int RANDOM_REQS = 80;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        itoa_pkg::radix_t radix;
        logic [63:0]      bits;
        bit               drain;
    } number_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_sym_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = '0;
    logic signed [63:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         text_char;
    logic               last;

    number_req_t numbers_to_send[$];
    text_sym_t   expected_chars[$];
    int          error_count = 0;
    int          cycle_count = 0;

    integer_to_ascii_radix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last      (last)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters still expected", $realtime,
                     expected_chars.size());
            $display("** integer_to_ascii_radix: FAILED **");
            $finish;
        end
    end

    // Random stalls on both sides, except for one long quiet stretch.
    function automatic bit stall_now();
        if (cycle_count >= 2000 && cycle_count < 5000)
            return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    function automatic logic [7:0] digit_glyph(logic [63:0] d);
        if (d < 10)
            return itoa_pkg::CHAR_ZERO + 8'(d);
        return itoa_pkg::CHAR_A_LOW + 8'(d - 10);
    endfunction

    task automatic predict_text(itoa_pkg::radix_t radix, logic [63:0] bits);
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0]  digits[$];
        bit          neg;
        text_sym_t   sym;
        mag = bits;
        neg = 1'b0;
        case (radix)
            itoa_pkg::RADIX_DEC:
            begin
                base = 64'd10;
                if (bits[63])
                begin
                    neg = 1'b1;
                    mag = ~bits + 64'd1;
                end
            end
            itoa_pkg::RADIX_HEX: base = 64'd16;
            itoa_pkg::RADIX_OCT: base = 64'd8;
            default:             base = 64'd2;
        endcase
        if (mag == 0)
            digits.push_front(itoa_pkg::CHAR_ZERO);
        while (mag != 0)
        begin
            digits.push_front(digit_glyph(mag % base));
            mag = mag / base;
        end
        if (neg)
        begin
            sym.ch = itoa_pkg::CHAR_MINUS;
            sym.last = 1'b0;
            expected_chars.push_back(sym);
        end
        foreach (digits[i])
        begin
            sym.ch = digits[i];
            sym.last = (i == digits.size() - 1);
            expected_chars.push_back(sym);
        end
    endtask

    task automatic note_error(string what, logic [7:0] want, logic [7:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, what, want, got);
    endtask

    task automatic add_number(itoa_pkg::radix_t radix, logic [63:0] bits, bit drain);
        number_req_t req;
        req.radix = radix;
        req.bits = bits;
        req.drain = drain;
        numbers_to_send.push_back(req);
    endtask

    // Request driver: a request marked drain waits until all text has come back.
    always @(posedge clk or negedge rst_n)
    begin
        logic        fire;
        number_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
                predict_text(itoa_pkg::radix_t'(cmd), value);
            if (!in_valid || fire)
            begin
                if (numbers_to_send.size() != 0 && !stall_now() &&
                    !(numbers_to_send[0].drain && expected_chars.size() != 0))
                begin
                    req = numbers_to_send.pop_front();
                    in_valid <= 1'b1;
                    cmd <= req.radix;
                    value <= req.bits;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        text_sym_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected character, expected none, actual %h last %b",
                             $realtime, text_char, last);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text_char !== want.ch)
                        note_error("text_char", want.ch, text_char);
                    if (last !== want.last)
                        note_error("last", 8'(want.last), 8'(last));
                end
            end
            out_ready <= !stall_now();
        end
    end

    initial
    begin
        logic [63:0]      bits;
        int               shape;
        itoa_pkg::radix_t radix;
        add_number(itoa_pkg::RADIX_DEC, 64'd0, 1'b0);
        add_number(itoa_pkg::RADIX_HEX, 64'd0, 1'b0);
        add_number(itoa_pkg::RADIX_OCT, 64'd0, 1'b0);
        add_number(itoa_pkg::RADIX_BIN, 64'd0, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'h7fff_ffff_ffff_ffff, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'h8000_0000_0000_0000, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'd1, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'd9, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'd10, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, -64'sd10, 1'b0);
        add_number(itoa_pkg::RADIX_DEC, 64'd1000000000000000000, 1'b1);
        add_number(itoa_pkg::RADIX_HEX, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_number(itoa_pkg::RADIX_HEX, 64'h8000_0000_0000_0000, 1'b0);
        add_number(itoa_pkg::RADIX_HEX, 64'h0123_4567_89ab_cdef, 1'b0);
        add_number(itoa_pkg::RADIX_HEX, 64'hfedc_ba98_7654_3210, 1'b0);
        add_number(itoa_pkg::RADIX_OCT, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_number(itoa_pkg::RADIX_OCT, 64'h8000_0000_0000_0000, 1'b0);
        add_number(itoa_pkg::RADIX_BIN, 64'hffff_ffff_ffff_ffff, 1'b0);
        add_number(itoa_pkg::RADIX_BIN, 64'd1, 1'b0);
        add_number(itoa_pkg::RADIX_BIN, 64'h8000_0000_0000_0000, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            radix = itoa_pkg::radix_t'($urandom_range(3));
            shape = $urandom_range(9);
            bits = {$urandom, $urandom};
            if (shape >= 4 && shape <= 7)
            begin
                bits = bits >> (64 - $urandom_range(64, 1));
                if ($urandom_range(3) == 0)
                    bits = ~bits + 64'd1;
            end
            else if (shape == 8)
            begin
                bits = 64'($urandom_range(20));
            end
            else if (shape == 9)
            begin
                case ($urandom_range(3))
                    0: bits = 64'hffff_ffff_ffff_ffff;
                    1: bits = 64'h8000_0000_0000_0000;
                    2: bits = 64'h7fff_ffff_ffff_ffff;
                    default: bits = 64'd1 << $urandom_range(63);
                endcase
            end
            add_number(radix, bits, i == 0 || $urandom_range(19) == 0);
        end

        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;

        while (numbers_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_chars.size() == 0)
            $display("** integer_to_ascii_radix: PASSED **");
        else
            $display("** integer_to_ascii_radix: FAILED **");
        $finish;
    end

endmodule
